// ===== sv/tlmf_pkg.sv =====
// ----------------------------------------------------------------------------
// tlmf_pkg
// Shared types, constants and helpers for the timeline to media frame mapper.
// ----------------------------------------------------------------------------
package tlmf_pkg;

    localparam int QS         = 16;   // Q16.16 fraction bits
    localparam int LEN_W      = 31;   // frame count width
    localparam int DVD_W      = 48;   // wrap dividend width
    localparam int DIV_STAGES = DVD_W;
    localparam int MQ_DEPTH   = 4;
    localparam int MQ_AW      = 2;
    localparam int OQ_DEPTH   = 2;

    // register indexes
    localparam logic [2:0] REG_CLIP_START  = 3'd0;
    localparam logic [2:0] REG_CLIP_LENGTH = 3'd1;
    localparam logic [2:0] REG_MEDIA_BASE  = 3'd2;
    localparam logic [2:0] REG_SRC_FRAMES  = 3'd3;
    localparam logic [2:0] REG_RATE_RATIO  = 3'd4;
    localparam logic [2:0] REG_OVERRUN     = 3'd5;
    localparam logic [2:0] REG_SECTION     = 3'd6;

    // overrun modes
    localparam logic [1:0] MODE_FREEZE   = 2'd0;
    localparam logic [1:0] MODE_LOOP     = 2'd1;
    localparam logic [1:0] MODE_PINGPONG = 2'd2;

    // mapping rule chosen for an item
    typedef enum logic [4:0] {
        PATH_TAIL   = 5'b00001,
        PATH_PHASE  = 5'b00010,
        PATH_ANCHOR = 5'b00100,
        PATH_END    = 5'b01000,
        PATH_NAT    = 5'b10000
    } t_path;

    typedef struct packed {
        logic [LEN_W-1:0] start;
        logic [LEN_W-1:0] length;
        logic [LEN_W-1:0] base;
        logic [LEN_W-1:0] len;      // effective source length, never zero
        logic [31:0]      ratio;
        logic [1:0]       mode;
        logic             normal;
    } t_cfg;

    // classified request from front to back
    typedef struct packed {
        t_path              path;
        logic               neg;
        logic [LEN_W-1:0]   mag;
        logic signed [32:0] off;
    } t_work;

    // side data carried through the divider
    typedef struct packed {
        t_path              path;
        logic signed [48:0] loc;
        logic               wrap;
    } t_tag;

    // one restoring division step: {quotient bit, new remainder}
    function automatic logic [LEN_W:0] div_step(input logic [LEN_W-1:0] rem,
                                                input logic            dbit,
                                                input logic [LEN_W-1:0] len);
        logic [LEN_W:0] t;
        logic [LEN_W:0] d;
        t = {rem, dbit};
        d = t - {1'b0, len};
        if (t >= {1'b0, len}) begin
            return {1'b1, d[LEN_W-1:0]};
        end
        return {1'b0, t[LEN_W-1:0]};
    endfunction

endpackage

// ===== sv/timeline_to_media_frame_mapper.sv =====
// ----------------------------------------------------------------------------
// timeline_to_media_frame_mapper
// Maps a timeline frame to a source media frame of the configured clip.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  request   in         i_push / o_full  timeline frame, phase data, anchors
//  result    out        o_empty / i_pop  o_media_frame
//  config    in         i_cfg_we         i_cfg_idx, i_cfg_data
//
//  One request per cycle sustained while the result queue has room; a request
//  passes the queue read, multiply, scale and offset stages, the 48-stage wrap
//  divider and the result write.
//  Reset is synchronous and clears both queues; registers take their defaults.
//  A full result queue stalls the back end; the 4-entry request queue keeps
//  accepting until it fills.
// ----------------------------------------------------------------------------
module timeline_to_media_frame_mapper import tlmf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_push,
    output logic               o_full,
    input  logic [30:0]        i_timeline_frame,
    input  logic               i_has_phase,
    input  logic               i_in_continuation,
    input  logic signed [47:0] i_phase_frames,
    input  logic signed [31:0] i_tail_hold_frame,
    input  logic signed [31:0] i_break_anchor,
    input  logic [30:0]        i_anchor_timeline,
    output logic               o_empty,
    input  logic               i_pop,
    output logic signed [31:0] o_media_frame
);

    logic [30:0] r_start, r_length, r_base, r_srcf;
    logic [31:0] r_ratio;
    logic [1:0]  r_mode;
    logic        r_normal;
    t_cfg        cfg;
    logic        mq_empty;
    logic        mq_pop;
    t_work       work;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_length <= '0;
            r_base   <= '0;
            r_srcf   <= 31'd1;
            r_ratio  <= 32'h0001_0000;
            r_mode   <= MODE_FREEZE;
            r_normal <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CLIP_START:  r_start  <= i_cfg_data[30:0];
                REG_CLIP_LENGTH: r_length <= i_cfg_data[30:0];
                REG_MEDIA_BASE:  r_base   <= i_cfg_data[30:0];
                REG_SRC_FRAMES:  r_srcf   <= i_cfg_data[30:0];
                REG_RATE_RATIO:  r_ratio  <= i_cfg_data;
                REG_OVERRUN:     r_mode   <= i_cfg_data[1:0];
                REG_SECTION:     r_normal <= i_cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        cfg.start  = r_start;
        cfg.length = r_length;
        cfg.base   = r_base;
        cfg.len    = (r_srcf == '0) ? 31'd1 : r_srcf;
        cfg.ratio  = r_ratio;
        cfg.mode   = r_mode;
        cfg.normal = r_normal;
    end

    tlmf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_timeline_frame (i_timeline_frame),
        .i_has_phase      (i_has_phase),
        .i_in_continuation(i_in_continuation),
        .i_phase_frames   (i_phase_frames),
        .i_tail_hold_frame(i_tail_hold_frame),
        .i_break_anchor   (i_break_anchor),
        .i_anchor_timeline(i_anchor_timeline),
        .i_pop            (mq_pop),
        .o_empty          (mq_empty),
        .o_work           (work)
    );

    tlmf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_q_empty    (mq_empty),
        .i_work       (work),
        .o_q_pop      (mq_pop),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_media_frame(o_media_frame)
    );

`ifndef SYNTHESIS
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> (o_empty && mq_empty))
        else $error("queues not empty after reset");
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full) |=> !mq_empty)
        else $error("accepted request missing from request queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mq_empty |-> !mq_pop)
        else $error("back end popped an empty request queue");
`endif

endmodule

// ===== sv/tlmf_front.sv =====
// ----------------------------------------------------------------------------
// tlmf_front
// Classifies each request by mapping rule and queues it for the back end.
// ----------------------------------------------------------------------------
module tlmf_front import tlmf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_push,
    output logic               o_full,
    input  logic [30:0]        i_timeline_frame,
    input  logic               i_has_phase,
    input  logic               i_in_continuation,
    input  logic signed [47:0] i_phase_frames,
    input  logic signed [31:0] i_tail_hold_frame,
    input  logic signed [31:0] i_break_anchor,
    input  logic [30:0]        i_anchor_timeline,
    input  logic               i_pop,
    output logic               o_empty,
    output t_work              o_work
);

    t_work            mq_mem [MQ_DEPTH];
    logic [MQ_AW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [MQ_AW:0]   r_cnt, n_cnt;
    t_work            w;
    logic [31:0]      clip_end;
    logic             past;
    logic [31:0]      delta;
    logic [31:0]      ndelta;
    logic             do_push, do_pop;

    // rule selection and offset setup
    always_comb begin
        clip_end = {1'b0, i_cfg.start} + {1'b0, i_cfg.length};
        past     = {1'b0, i_timeline_frame} >= clip_end;
        delta    = {1'b0, i_timeline_frame} - {1'b0, i_cfg.start};
        w.off    = '0;
        if (past && i_has_phase && !i_tail_hold_frame[31]) begin
            w.path = PATH_TAIL;
            w.off  = 33'(i_tail_hold_frame);
        end else if (i_has_phase && i_in_continuation && i_cfg.normal) begin
            w.path = PATH_PHASE;
            w.off  = i_phase_frames[47] ? '0 : {1'b0, i_phase_frames[47:16]};
        end else if (i_has_phase && !i_break_anchor[31] && !past) begin
            w.path = PATH_ANCHOR;
            delta  = {1'b0, i_timeline_frame} - {1'b0, i_anchor_timeline};
            w.off  = 33'(i_break_anchor) - $signed({2'b00, i_cfg.base});
        end else if (past) begin
            w.path = PATH_END;
        end else begin
            w.path = PATH_NAT;
        end
        ndelta = -delta;
        w.neg  = delta[31];
        w.mag  = delta[31] ? ndelta[30:0] : delta[30:0];
        if (w.path == PATH_TAIL || w.path == PATH_PHASE || w.path == PATH_END) begin
            w.neg = 1'b0;
            w.mag = '0;
        end
    end

    // request queue
    assign o_full  = (r_cnt == (MQ_AW+1)'(MQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + {{MQ_AW{1'b0}}, do_push} - {{MQ_AW{1'b0}}, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mq_mem[r_wr] <= w;
        end
    end

    assign o_work = mq_mem[r_rd];

endmodule

// ===== sv/tlmf_div.sv =====
// ----------------------------------------------------------------------------
// tlmf_div
// Pipelined restoring divider, one quotient bit per stage, for source wrap.
// ----------------------------------------------------------------------------
module tlmf_div import tlmf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [DVD_W-1:0] i_dvd,
    input  logic [LEN_W-1:0] i_len,
    input  t_tag             i_tag,
    output logic             o_vld,
    output logic [LEN_W-1:0] o_rem,
    output logic             o_qlsb,
    output t_tag             o_tag
);

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic [LEN_W:0]   n_step;
        logic             in_vld;
        logic [LEN_W-1:0] in_rem;
        logic [DVD_W-1:0] in_dvd;
        t_tag             in_tag;
        logic             r_vld;
        logic [LEN_W-1:0] r_rem;
        logic [DVD_W-1:0] r_dvd;
        logic             r_q;
        t_tag             r_tag;

        if (g == 0) begin : g_first
            assign in_vld = i_vld;
            assign in_rem = '0;
            assign in_dvd = i_dvd;
            assign in_tag = i_tag;
        end else begin : g_next
            assign in_vld = g_stage[g-1].r_vld;
            assign in_rem = g_stage[g-1].r_rem;
            assign in_dvd = g_stage[g-1].r_dvd;
            assign in_tag = g_stage[g-1].r_tag;
        end

        assign n_step = div_step(in_rem, in_dvd[DVD_W-1-g], i_len);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_step[LEN_W-1:0];
                r_q   <= n_step[LEN_W];
                r_dvd <= in_dvd;
                r_tag <= in_tag;
            end
        end
    end

    assign o_vld  = g_stage[DIV_STAGES-1].r_vld;
    assign o_rem  = g_stage[DIV_STAGES-1].r_rem;
    assign o_qlsb = g_stage[DIV_STAGES-1].r_q;
    assign o_tag  = g_stage[DIV_STAGES-1].r_tag;

endmodule

// ===== sv/tlmf_back.sv =====
// ----------------------------------------------------------------------------
// tlmf_back
// Scales, offsets, wraps and saturates queued requests; holds finished results.
// ----------------------------------------------------------------------------
module tlmf_back import tlmf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_empty,
    input  t_work              i_work,
    output logic               o_q_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output logic signed [31:0] o_media_frame
);

    logic               en;
    // stage 1: request taken from queue
    logic               r1_v;
    t_work              r1_w;
    // stage 2: product
    logic               r2_v;
    t_path              r2_path;
    logic               r2_neg;
    logic signed [32:0] r2_off;
    logic [62:0]        r2_prod;
    // stage 3: floored scale
    logic               r3_v;
    t_path              r3_path;
    logic signed [32:0] r3_off;
    logic signed [48:0] r3_scale;
    // stage 4: source offset
    logic               r4_v;
    t_path              r4_path;
    logic signed [48:0] r4_loc;

    logic [47:0]        q_up;
    logic signed [48:0] n3_scale;
    logic signed [48:0] n4_loc;
    t_tag               d_tag;
    logic               d_vld;
    logic [LEN_W-1:0]   d_rem;
    logic               d_q;
    t_tag               d_otag;
    logic signed [48:0] v;
    logic signed [49:0] sum;
    logic signed [31:0] res;

    logic signed [31:0] oq_mem [OQ_DEPTH];
    logic               r_wr, r_rd;
    logic [1:0]         r_cnt;
    logic               oq_push, oq_pop;

    assign en      = (r_cnt != 2'(OQ_DEPTH));
    assign o_q_pop = en && !i_q_empty;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (en) begin
            r1_v <= !i_q_empty;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    // scale: floor toward minus infinity of delta * ratio / 2^16
    always_comb begin
        q_up     = {1'b0, r2_prod[62:QS]} + {47'b0, (r2_prod[QS-1:0] != '0)};
        n3_scale = r2_neg ? -$signed({1'b0, q_up}) : $signed({1'b0, r2_prod[62:QS]});
    end

    // source offset per rule
    always_comb begin
        n4_loc = 49'(r3_off) + r3_scale;
        case (r3_path)
            PATH_ANCHOR: if (n4_loc[48]) n4_loc = '0;
            PATH_END:    n4_loc = $signed({18'b0, i_cfg.len}) - 49'sd1;
            PATH_TAIL,
            PATH_PHASE:  n4_loc = 49'(r3_off);
            default:     ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_w     <= i_work;
            r2_path  <= r1_w.path;
            r2_neg   <= r1_w.neg;
            r2_off   <= r1_w.off;
            r2_prod  <= 63'({32'b0, r1_w.mag} * {31'b0, i_cfg.ratio});
            r3_path  <= r2_path;
            r3_off   <= r2_off;
            r3_scale <= n3_scale;
            r4_path  <= r3_path;
            r4_loc   <= n4_loc;
        end
    end

    // wrap decision goes along with the division
    always_comb begin
        d_tag.path = r4_path;
        d_tag.loc  = r4_loc;
        d_tag.wrap = (r4_path != PATH_TAIL) && !r4_loc[48]
                     && (r4_loc >= $signed({18'b0, i_cfg.len}));
    end

    tlmf_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r4_v),
        .i_dvd  (r4_loc[DVD_W-1:0]),
        .i_len  (i_cfg.len),
        .i_tag  (d_tag),
        .o_vld  (d_vld),
        .o_rem  (d_rem),
        .o_qlsb (d_q),
        .o_tag  (d_otag)
    );

    // overrun rule, media base and saturation
    always_comb begin
        v = d_otag.loc;
        if (d_otag.wrap) begin
            case (i_cfg.mode)
                MODE_LOOP:     v = $signed({18'b0, d_rem});
                MODE_PINGPONG: v = d_q ? $signed({18'b0, i_cfg.len - d_rem - 1'b1})
                                       : $signed({18'b0, d_rem});
                default:       v = $signed({18'b0, i_cfg.len}) - 49'sd1;
            endcase
        end
        sum = $signed({19'b0, i_cfg.base}) + 50'(v);
        if (sum > 50'sh0_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (sum < -50'sh0_8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = sum[31:0];
        end
        if (d_otag.path == PATH_TAIL) begin
            res = d_otag.loc[31:0];
        end
    end

    // result queue
    assign oq_push = en && d_vld;
    assign oq_pop  = i_pop && !o_empty;
    assign o_empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (oq_push) r_wr <= ~r_wr;
            if (oq_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, oq_push} - {1'b0, oq_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            oq_mem[r_wr] <= res;
        end
    end

    assign o_media_frame = oq_mem[r_rd];

endmodule

// ===== dv/timeline_to_media_frame_mapper_test.sv =====
// ----------------------------------------------------------------------------
// timeline_to_media_frame_mapper_test
// Drives frame-mapping requests through the queue ports under several clip
// settings, predicts every media frame and checks it against the results.
// ----------------------------------------------------------------------------
module timeline_to_media_frame_mapper_test;
    import tlmf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [30:0]        tl;
        logic               hp;
        logic               cont;
        logic signed [47:0] phase;
        logic signed [31:0] tail;
        logic signed [31:0] anchor;
        logic [30:0]        anchor_tl;
    } t_req;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_push = 1'b0;
    logic               o_full;
    t_req               drv_req = '0;
    logic               o_empty;
    logic               i_pop = 1'b0;
    logic signed [31:0] o_media_frame;

    timeline_to_media_frame_mapper dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_push(i_push), .o_full(o_full),
        .i_timeline_frame(drv_req.tl), .i_has_phase(drv_req.hp),
        .i_in_continuation(drv_req.cont), .i_phase_frames(drv_req.phase),
        .i_tail_hold_frame(drv_req.tail), .i_break_anchor(drv_req.anchor),
        .i_anchor_timeline(drv_req.anchor_tl),
        .o_empty(o_empty), .i_pop(i_pop), .o_media_frame(o_media_frame)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // clip settings as the predictor sees them
    longint clip_start_q, clip_len_q, base_q, src_q, ratio_q;
    logic [1:0] mode_q;
    logic       normal_q;

    t_req             pending_reqs[$];
    logic signed [31:0] expected_frames[$];
    int  errors = 0;
    longint cycles = 0;

    function automatic longint scale_floor(longint delta, longint ratio);
        longint mag, q;
        logic [63:0] prod;
        mag = (delta < 0) ? -delta : delta;
        prod = mag * ratio;
        q = prod >> 16;
        if (delta < 0) return (prod[15:0] != 0) ? -(q + 1) : -q;
        return q;
    endfunction

    function automatic longint apply_overrun(longint loc, longint len);
        if (loc < len) return loc;
        if (mode_q == MODE_LOOP) return loc % len;
        if (mode_q == MODE_PINGPONG)
            return ((loc / len) % 2 == 0) ? loc % len : len - 1 - (loc % len);
        return len - 1;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] map_frame(t_req r);
        longint tf, clip_end, len, loc;
        tf = r.tl;
        clip_end = clip_start_q + clip_len_q;
        len = (src_q == 0) ? 1 : src_q;
        if (tf >= clip_end && r.hp && r.tail >= 0) return clamp32(r.tail);
        if (r.hp && r.cont && normal_q) begin
            loc = (r.phase < 0) ? 0 : (longint'(r.phase) >>> 16);
            return clamp32(base_q + apply_overrun(loc, len));
        end
        if (r.hp && r.anchor >= 0 && tf < clip_end) begin
            loc = (longint'(r.anchor) - base_q)
                + scale_floor(tf - longint'(r.anchor_tl), ratio_q);
            if (loc < 0) loc = 0;
            return clamp32(base_q + apply_overrun(loc, len));
        end
        if (tf >= clip_end) return clamp32(base_q + len - 1);
        return clamp32(base_q + apply_overrun(scale_floor(tf - clip_start_q, ratio_q), len));
    endfunction

    // append a request to the pending list
    function automatic void add_req(t_req r);
        pending_reqs = {pending_reqs, r};
    endfunction

    // request driver with random gaps
    int push_gap = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_push && !o_full) begin
            expected_frames = {expected_frames, map_frame(drv_req)};
            void'(pending_reqs.pop_front());
            push_gap = $urandom_range(0, 13);
            if ($urandom_range(0, 3) == 0) push_gap = 0;
        end
        if (i_push && o_full) begin
            // hold the request
        end else if (push_gap > 0) begin
            push_gap--;
            i_push <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            i_push <= 1'b1;
            drv_req <= pending_reqs[0];
        end else begin
            i_push <= 1'b0;
        end
    end

    // result monitor with random stalls
    int pop_gap = 0;
    always @(posedge i_clk) begin
        if (i_pop && !o_empty) begin
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected result %0d", $time, o_media_frame);
                errors++;
            end else begin
                if (o_media_frame !== expected_frames[0]) begin
                    $display("%0t: media_frame expected %0d actual %0d",
                             $time, expected_frames[0], o_media_frame);
                    errors++;
                end
                void'(expected_frames.pop_front());
            end
            pop_gap = $urandom_range(0, 13);
            if ($urandom_range(0, 3) == 0) pop_gap = 0;
        end
        if (pop_gap > 0) begin
            pop_gap--;
            i_pop <= 1'b0;
        end else begin
            i_pop <= 1'b1;
        end
    end

    // timeout
    always @(posedge i_clk) begin
        if (cycles > 1000000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_CLIP_START:  clip_start_q = val[30:0];
            REG_CLIP_LENGTH: clip_len_q = val[30:0];
            REG_MEDIA_BASE:  base_q = val[30:0];
            REG_SRC_FRAMES:  src_q = val[30:0];
            REG_RATE_RATIO:  ratio_q = val;
            REG_OVERRUN:     mode_q = val[1:0];
            REG_SECTION:     normal_q = val[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || i_push || expected_frames.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_wide(logic [31:0] small_max);
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, small_max);
            1: return $urandom;
            2: return 32'h7fffffff - $urandom_range(0, 3);
            default: return $urandom_range(0, 4);
        endcase
    endfunction

    // request near the clip, mostly well-formed
    function automatic t_req rand_req();
        t_req r;
        longint s;
        s = clip_start_q;
        r.tl = ($urandom_range(0, 7) == 0) ? 31'($urandom) :
               31'(s + clip_len_q - 4 + $urandom_range(0, 8) - $urandom_range(0, 20));
        if ($urandom_range(0, 1)) r.tl = 31'(s + $urandom_range(0, 40)) - 31'($urandom_range(0, 3));
        r.hp = $urandom_range(0, 3) != 0;
        r.cont = 1'($urandom_range(0, 1));
        r.phase = 48'({$urandom, $urandom});
        if ($urandom_range(0, 1)) r.phase = 48'($urandom_range(0, 200)) << 16 | 48'($urandom_range(0, 65535));
        r.tail = ($urandom_range(0, 1)) ? 32'($urandom) : -32'sd1;
        r.anchor = ($urandom_range(0, 2) == 0) ? 32'($urandom) :
                   32'(base_q + $urandom_range(0, 30));
        r.anchor_tl = ($urandom_range(0, 3) == 0) ? 31'($urandom) :
                      31'(s + $urandom_range(0, 40));
        return r;
    endfunction

    initial begin
        t_req r;
        clip_start_q = 0; clip_len_q = 0; base_q = 0; src_q = 1;
        ratio_q = 65536; mode_q = MODE_FREEZE; normal_q = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: clip at 100, length 50, base 1000, 10 source frames
        write_reg(REG_CLIP_START, 100);
        write_reg(REG_CLIP_LENGTH, 50);
        write_reg(REG_MEDIA_BASE, 1000);
        write_reg(REG_SRC_FRAMES, 10);
        write_reg(REG_RATE_RATIO, 32'h0001_8000);
        write_reg(REG_OVERRUN, MODE_PINGPONG);
        write_reg(REG_SECTION, 1);
        r = '0;
        r.tail = -1; r.anchor = -1;
        r.tl = 110; add_req(r);           // natural
        r.tl = 90; add_req(r);            // before clip start
        r.tl = 149; add_req(r);           // overrun
        r.tl = 200; add_req(r);           // past end, no tail
        r.tl = 31'h7fffffff; add_req(r);
        r.hp = 1; r.tail = 32'sh7fffffff; add_req(r); // tail hold
        r.tail = 0; r.tl = 150; add_req(r);
        r.tl = 120; r.cont = 1; r.phase = 48'sh0000_0012_8000; add_req(r);
        r.phase = -48'sd5; add_req(r);     // negative phase
        r.phase = 48'sh7fff_ffff_ffff; add_req(r);
        r.phase = 48'sh8000_0000_0000; add_req(r);
        r.cont = 0; r.anchor = 1003; r.anchor_tl = 130; add_req(r); // anchor
        r.anchor = 0; add_req(r);          // clamped to zero
        r.anchor = 32'sh7fffffff; r.anchor_tl = 0; add_req(r);
        drain();

        // corner settings: unused mode, zero source, extremes
        write_reg(REG_OVERRUN, 3);
        write_reg(REG_SRC_FRAMES, 0);
        write_reg(REG_RATE_RATIO, 32'hffff_ffff);
        write_reg(REG_MEDIA_BASE, 32'h7fff_ffff);
        write_reg(REG_SECTION, 0);
        write_reg(REG_CLIP_START, 32'h7fff_ffff);
        r = '0; r.tail = -1; r.anchor = -1;
        r.tl = 140; add_req(r);
        r.hp = 1; r.cont = 1; r.phase = 48'sh0000_0100_0000; add_req(r);
        drain();

        // random phases, each with fresh settings
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(REG_CLIP_START, rand_wide(1000));
            write_reg(REG_CLIP_LENGTH, rand_wide(200));
            write_reg(REG_MEDIA_BASE, rand_wide(5000));
            write_reg(REG_SRC_FRAMES, rand_wide(60));
            write_reg(REG_RATE_RATIO, ($urandom_range(0, 2) == 0) ? $urandom :
                                      $urandom_range(0, 32'h0004_0000));
            write_reg(REG_OVERRUN, $urandom_range(0, 3));
            write_reg(REG_SECTION, $urandom_range(0, 1));
            for (int k = 0; k < 100; k++) add_req(rand_req());
            drain();
        end

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/tlmf_pkg.sv
sv/tlmf_front.sv
sv/tlmf_div.sv
sv/tlmf_back.sv
sv/timeline_to_media_frame_mapper.sv
dv/timeline_to_media_frame_mapper_test.sv
